/* sv/cascade_pairwise_summation_defines.svh */
// assertion macros for the cascade summation block
`ifndef CASCADE_PAIRWISE_SUMMATION_DEFINES_SVH
`define CASCADE_PAIRWISE_SUMMATION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/cps_pkg.sv */
package cps_pkg;
    localparam int unsigned DefLevels = 32;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_WAIT,
        ST_SUM,
        ST_SWAIT,
        ST_CLEAR,
        ST_OUT
    } t_state;

    function automatic logic is_zero(input logic [63:0] v);
        return v[62:0] == 63'd0;
    endfunction
endpackage

/* sv/cascade_pairwise_summation.sv */
// Cascade summation of IEEE doubles. One request at a time: an add walks the
// ladder of partial sums from level 0, folding each occupied level into the
// carry through one shared four-stage double adder, a query accumulates every
// level through the same adder, and a clear sweeps the ladder one level a
// cycle. After reset the same sweep runs, so the first request is taken only
// once it has finished. The adder latency and the serial carry dependence set
// how long a request takes. The query result sits in an output register until
// taken; new requests are accepted meanwhile, and only a following query waits
// for that register to drain.
`include "cascade_pairwise_summation_defines.svh"
module cascade_pairwise_summation #(
    parameter int unsigned LEVELS = cps_pkg::DefLevels
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // summand[63:0]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // total[63:0]
    output logic        m_axis_tuser    // overflowed
);
    import cps_pkg::*;
    localparam int IW = $clog2(LEVELS);

    // partial sum ladder in a memory with one write port and one registered read port
    logic [63:0] r_mem [LEVELS];
    logic [63:0] r_rd;
    t_state      r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [63:0] r_acc, n_acc;
    logic        r_ovf, n_ovf;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_otot, n_otot;
    logic        r_oovf, n_oovf;
    logic        r_rdok, n_rdok;
    logic        we;
    logic [IW-1:0] waddr;
    logic [63:0] wdata;
    logic        add_go;
    logic [63:0] add_b;
    logic        add_done;
    logic [63:0] add_sum;
    logic        top;

    cps_fadd u_add (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(add_go),
        .i_a    (r_acc),
        .i_b    (add_b),
        .o_done (add_done),
        .o_sum  (add_sum)
    );

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_idx    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_rdok   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
            r_rdok   <= n_rdok;
        end
        r_acc  <= n_acc;
        r_otot <= n_otot;
        r_oovf <= n_oovf;
    end

    assign top = (r_idx == IW'(LEVELS - 1));
    assign add_b = r_rd;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_ovalid = r_ovalid;
        n_otot   = r_otot;
        n_oovf   = r_oovf;
        n_rdok   = 1'b0;
        we       = 1'b0;
        waddr    = r_idx;
        wdata    = 64'd0;
        add_go   = 1'b0;
        s_axis_tready = 1'b0;
        if (m_axis_tready) n_ovalid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                n_idx = '0;
                if (s_axis_tvalid) begin
                    n_rdok = 1'b1;
                    unique case (t_op'(s_axis_tuser))
                        OP_ADD: begin
                            n_acc = s_axis_tdata;
                            n_state = ST_WALK;
                        end
                        OP_QUERY: begin
                            n_acc = 64'd0;
                            n_state = ST_SUM;
                        end
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                // r_rd holds level r_idx
                if (!r_rdok) begin
                    n_rdok = 1'b1;
                end else if (top) begin
                    add_go = 1'b1;
                    n_ovf = 1'b1;
                    n_state = ST_WAIT;
                end else if (is_zero(r_rd)) begin
                    we = 1'b1;
                    wdata = r_acc;
                    n_state = ST_IDLE;
                end else begin
                    add_go = 1'b1;
                    we = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (add_done) begin
                    n_acc = add_sum;
                    if (top) begin
                        we = 1'b1;
                        wdata = add_sum;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_state = ST_WALK;
                    end
                end
            end
            ST_SUM: begin
                if (!r_rdok) begin
                    n_rdok = 1'b1;
                end else begin
                    add_go = 1'b1;
                    n_state = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                if (add_done) begin
                    n_acc = add_sum;
                    if (top) begin
                        n_state = ST_OUT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_state = ST_SUM;
                    end
                end
            end
            ST_CLEAR: begin
                we = 1'b1;
                if (top) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_OUT: begin
                // hand the total over once the output register is free
                if (!r_ovalid || m_axis_tready) begin
                    n_otot = r_acc;
                    n_oovf = r_ovf;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otot;
    assign m_axis_tuser  = r_oovf;

    `CPS_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready)
    `CPS_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n, r_ovf, r_ovf)
    `CPS_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= IW'(LEVELS - 1))
    `CPS_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, add_done,
        r_state == ST_WAIT || r_state == ST_SWAIT)
endmodule

/* sv/cps_fadd.sv */
module cps_fadd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_sum
);
    import cps_pkg::*;

    // stage 1: specials, swap, align
    logic        r_v1, r_v2, r_v3;
    logic        r_sp1, r_sp2, r_sp3;
    logic [63:0] r_spv1, r_spv2, r_spv3;
    logic        r_sa1, r_sb1;
    logic [10:0] r_e1;
    logic [55:0] r_ma1, r_mb1;
    logic        r_sub1;
    logic        r_sgn2;
    logic [10:0] r_e2;
    logic [56:0] r_m2;
    logic        r_sgn3;
    logic [11:0] r_e3;
    logic [55:0] r_m3;
    logic        r_zero3;
    logic [63:0] r_res;
    logic        r_v4;

    logic [10:0] ea, eb, eax, ebx, sh;
    logic [52:0] fa, fb;
    logic        swp, a_nan, b_nan, a_inf, b_inf;
    logic [63:0] x, y;
    logic [55:0] mx, my, myal;
    logic [11:0] dexp;
    logic        stick;
    logic [63:0] spval;
    logic        spc;

    always_comb begin
        ea = i_a[62:52];
        eb = i_b[62:52];
        swp = {ea, i_a[51:0]} < {eb, i_b[51:0]};
        x = swp ? i_b : i_a;
        y = swp ? i_a : i_b;
        eax = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
        ebx = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
        fa = {x[62:52] != 11'd0, x[51:0]};
        fb = {y[62:52] != 11'd0, y[51:0]};
        mx = {fa, 3'b000};
        my = {fb, 3'b000};
        dexp = {1'b0, eax} - {1'b0, ebx};
        sh = (dexp > 12'd56) ? 11'd56 : dexp[10:0];
        myal = my >> sh;
        stick = (my & ((56'd1 << sh) - 56'd1)) != 56'd0;
        a_nan = (ea == 11'h7ff) && (i_a[51:0] != 52'd0);
        b_nan = (eb == 11'h7ff) && (i_b[51:0] != 52'd0);
        a_inf = (ea == 11'h7ff) && (i_a[51:0] == 52'd0);
        b_inf = (eb == 11'h7ff) && (i_b[51:0] == 52'd0);
        spc = 1'b1;
        // a nan operand passes through quieted, the first operand winning
        if (a_nan) begin
            spval = {i_a[63:52], 1'b1, i_a[50:0]};
        end else if (b_nan) begin
            spval = {i_b[63:52], 1'b1, i_b[50:0]};
        end else if (a_inf && b_inf && (i_a[63] != i_b[63])) begin
            // opposite infinities give the default nan
            spval = 64'hfff8_0000_0000_0000;
        end else if (a_inf) begin
            spval = i_a;
        end else if (b_inf) begin
            spval = i_b;
        end else begin
            spc = 1'b0;
            spval = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    logic [56:0] msum;
    logic [5:0]  lz;
    logic [56:0] mnorm;
    logic [12:0] enorm;
    logic        fz;

    always_comb begin
        msum = r_sub1 ? ({1'b0, r_ma1} - {1'b0, r_mb1}) : ({1'b0, r_ma1} + {1'b0, r_mb1});
    end

    always_comb begin
        lz = 6'd0;
        fz = (r_m2 == 57'd0);
        for (int k = 0; k < 57; k++) begin
            if (r_m2[k]) lz = 6'(56 - k);
        end
    end

    // normalize: value = m2 * 2^(e2-55) ; target bit 55 leading
    logic [56:0] mshift;
    logic [12:0] eadj;
    logic        sticky2;
    always_comb begin
        sticky2 = 1'b0;
        if (r_m2[56]) begin
            mshift = r_m2 >> 1;
            sticky2 = r_m2[0];
            eadj = {2'b00, r_e2} + 13'd1;
        end else begin
            if ({7'd0, lz} - 13'd1 >= {2'b00, r_e2}) begin
                mshift = r_m2 << (r_e2 - 11'd1);
                eadj = 13'd0;
            end else begin
                mshift = r_m2 << (lz - 6'd1);
                eadj = {2'b00, r_e2} - {7'd0, lz} + 13'd1;
            end
        end
        mnorm = mshift;
        enorm = eadj;
    end

    logic [52:0] rm;
    logic        rup;
    logic [53:0] rsum;
    logic [11:0] rexp;
    always_comb begin
        rm = r_m3[55:3];
        rup = r_m3[2] && (r_m3[1] || r_m3[0] || r_m3[3]);
        rsum = {1'b0, rm} + {53'd0, rup};
        rexp = r_e3;
        if (rsum[53]) begin
            rexp = r_e3 + 12'd1;
        end else if (r_e3 == 12'd0 && rsum[52]) begin
            rexp = 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp1 <= spc; r_spv1 <= spval;
        r_sa1 <= x[63]; r_sb1 <= y[63];
        r_e1 <= eax;
        r_ma1 <= mx;
        r_mb1 <= {myal[55:1], myal[0] | stick};
        r_sub1 <= x[63] ^ y[63];
        // stage 2
        r_sp2 <= r_sp1; r_spv2 <= r_spv1;
        r_m2 <= msum;
        r_e2 <= r_e1;
        r_sgn2 <= (msum == 57'd0) ? (r_sa1 & r_sb1) : r_sa1;
        // stage 3
        r_sp3 <= r_sp2; r_spv3 <= r_spv2;
        r_sgn3 <= r_sgn2;
        r_zero3 <= fz;
        r_e3 <= enorm[11:0];
        r_m3 <= {mnorm[55:1], mnorm[0] | sticky2};
        // stage 4
        if (r_sp3) begin
            r_res <= r_spv3;
        end else if (r_zero3) begin
            r_res <= {r_sgn3, 63'd0};
        end else if (rexp >= 12'h7ff) begin
            r_res <= {r_sgn3, 11'h7ff, 52'd0};
        end else if (rsum[53]) begin
            r_res <= {r_sgn3, rexp[10:0], rsum[52:1]};
        end else begin
            r_res <= {r_sgn3, rexp[10:0], rsum[51:0]};
        end
    end

    assign o_done = r_v4;
    assign o_sum  = r_res;
endmodule

/* tb/cascade_pairwise_summation_test.sv */
`timescale 1ns / 1ps

module cascade_pairwise_summation_test;
    import cps_pkg::*;

    localparam int unsigned Levels     = DefLevels;
    localparam int unsigned CycleLimit = 2000000;

    typedef struct {
        logic [63:0] total;
        logic        overflowed;
    } t_total;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // summand[63:0]
    logic [1:0]  s_axis_tuser;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // total[63:0]
    logic        m_axis_tuser;   // overflowed

    // predicted ladder of partial sums, kept in native double precision
    real         ladder[Levels];
    logic        ladder_overflow;
    t_total      totals_due[$];

    int          errors;
    int          requests_sent;
    int          totals_checked;
    int          cycles;
    bit          no_stall;

    cascade_pairwise_summation u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // binary-counter carry walk; the top level absorbs the carry and sets the flag
    function automatic void ladder_add(input logic [63:0] bits);
        real carry;
        int  lvl;
        carry = $bitstoreal(bits);
        lvl = 0;
        while (lvl < Levels - 1 && ladder[lvl] != 0.0) begin
            carry = carry + ladder[lvl];
            ladder[lvl] = 0.0;
            lvl++;
        end
        if (lvl == Levels - 1) begin
            ladder[lvl] = carry + ladder[lvl];
            ladder_overflow = 1'b1;
        end else begin
            ladder[lvl] = carry;
        end
    endfunction

    // sum from level 0 upward starting at +0
    function automatic logic [63:0] ladder_total();
        real acc;
        acc = 0.0;
        for (int i = 0; i < Levels; i++) acc = acc + ladder[i];
        return $realtobits(acc);
    endfunction

    function automatic void ladder_clear();
        for (int i = 0; i < Levels; i++) ladder[i] = 0.0;
    endfunction

    function automatic void predict(input t_op op, input logic [63:0] summand);
        t_total t;
        unique case (op)
            OP_ADD: ladder_add(summand);
            OP_QUERY: begin
                t.total      = ladder_total();
                t.overflowed = ladder_overflow;
                totals_due.push_back(t);
            end
            OP_CLEAR: ladder_clear();
            default: ;
        endcase
    endfunction

    // one request: optional gap with tvalid low, then hold until accepted
    task automatic send_request(input t_op op, input logic [63:0] summand);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= summand;
        do @(posedge i_clk); while (!s_axis_tready);
        predict(op, summand);
        requests_sent++;
    endtask

    task automatic release_bus();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random double spread over a moderate exponent range, sometimes raw bits
    function automatic logic [63:0] pick_summand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 9) != 0)
            v[62:52] = 11'd1023 + 11'($urandom_range(0, 80)) - 11'd40;
        if ($urandom_range(0, 19) == 0) v = {v[63], 63'd0};
        return v;
    endfunction

    // output side: each result waits a random number of cycles before ready
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && !m_axis_tready) begin
                stall = no_stall ? 0 : $urandom_range(0, 19);
                repeat (stall) @(posedge i_clk);
                m_axis_tready <= 1'b1;
                do @(posedge i_clk); while (!m_axis_tvalid);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_total want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (totals_due.size() == 0) begin
                $error("unexpected total %h", m_axis_tdata);
                errors++;
            end else begin
                want = totals_due.pop_front();
                totals_checked++;
                if (m_axis_tdata !== want.total) begin
                    $error("total: expected %h actual %h", want.total, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.overflowed) begin
                    $error("overflowed: expected %b actual %b",
                           want.overflowed, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("FAIL cascade_pairwise_summation");
            $finish;
        end
    end

    // extremes, signed zeros, infinities, nan, unused op and clear
    task automatic test_directed();
        send_request(OP_QUERY, 64'd0);
        send_request(OP_ADD, 64'h0000_0000_0000_0000);
        send_request(OP_ADD, 64'h8000_0000_0000_0000);
        send_request(OP_QUERY, 64'd0);
        send_request(OP_ADD, 64'h3FF0_0000_0000_0000);
        send_request(OP_ADD, 64'h8000_0000_0000_0000);
        send_request(OP_ADD, 64'hBFF0_0000_0000_0000);
        send_request(OP_QUERY, 64'd0);
        send_request(OP_ADD, 64'h7FEF_FFFF_FFFF_FFFF);
        send_request(OP_ADD, 64'h7FEF_FFFF_FFFF_FFFF);
        send_request(OP_ADD, 64'h0000_0000_0000_0001);
        send_request(OP_QUERY, 64'd0);
        send_request(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_QUERY, 64'd0);
        send_request(OP_ADD, 64'h7FF0_0000_0000_0000);
        send_request(OP_ADD, 64'hFFF0_0000_0000_0000);
        send_request(OP_QUERY, 64'd0);
        send_request(OP_CLEAR, 64'd0);
        send_request(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_NONE, 64'h4000_0000_0000_0000);
        send_request(OP_QUERY, 64'd0);
        send_request(OP_CLEAR, 64'd0);
        send_request(OP_NONE, 64'd0);
        send_request(OP_QUERY, 64'd0);
    endtask

    // runs of adds with a query now and then and a rare clear or unused op, the ladder growing deep
    task automatic test_random_sums(input int count, input bit tight);
        int pick;
        no_stall = tight;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 84)      send_request(OP_ADD, pick_summand());
            else if (pick < 96) send_request(OP_QUERY, {$urandom, $urandom});
            else if (pick < 98) send_request(OP_CLEAR, {$urandom, $urandom});
            else                send_request(OP_NONE, {$urandom, $urandom});
        end
        send_request(OP_QUERY, 64'd0);
        no_stall = 1'b0;
    endtask

    initial begin
        errors = 0;
        requests_sent = 0;
        totals_checked = 0;
        cycles = 0;
        no_stall = 1'b0;
        ladder_overflow = 1'b0;
        ladder_clear();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_ADD;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_sums(900, 1'b0);
        test_random_sums(200, 1'b1);
        test_random_sums(700, 1'b0);
        release_bus();

        while (totals_due.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("covered %0d requests (adds, queries, clears, unused op), %0d totals checked",
                 requests_sent, totals_checked);
        if (errors == 0) begin
            $display("PASS cascade_pairwise_summation");
        end else begin
            $display("FAIL cascade_pairwise_summation");
        end
        $finish;
    end
endmodule
